>>> hdl/assert_macros.svh
// Assertion macros for the checker file of the text console writer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

>>> hdl/tcw_pkg.sv
// Package of the text console writer: geometry, codes and shared types.
package tcw_pkg;

	localparam int COLS   = 80;
	localparam int ROWS   = 25;
	localparam int CELLS  = COLS * ROWS;
	localparam int COL_W  = $clog2(COLS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int ADDR_W = $clog2(CELLS);

	// Fixed widths of the result fields.
	localparam int OUT_COL_W = 7;
	localparam int OUT_ROW_W = 5;
	localparam int OUT_POS_W = 11;

	localparam logic [7:0]  CH_LINE_FEED = 8'h0A;
	localparam logic [7:0]  CH_CARRIAGE  = 8'h0D;
	localparam logic [7:0]  CH_SPACE     = 8'h20;
	localparam logic [15:0] RESET_CELL   = 16'h0720;
	localparam logic [3:0]  RESET_FG     = 4'h7;
	localparam logic [3:0]  RESET_BG     = 4'h0;

	localparam logic [7:0] REG_FG_COLOR = 8'd0;
	localparam logic [7:0] REG_BG_COLOR = 8'd1;

	typedef enum logic [1:0] {
		REQ_PUT   = 2'd0,
		REQ_CLEAR = 2'd1,
		REQ_MOVE  = 2'd2,
		REQ_READ  = 2'd3
	} req_t;

	// Write and read request toward the cell memory.
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [15:0]       wdata;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	// Finished result handed from the sequencer to the output register.
	typedef struct packed {
		logic              valid;
		logic [15:0]       cell_val;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [ADDR_W-1:0] pos;
	} result_t;

endpackage

>>> hdl/tcw_addr_unit.sv
// Shared address unit: linear cell index from a row and a column.
module tcw_addr_unit (
	input  logic [tcw_pkg::ROW_W-1:0]  row,
	input  logic [tcw_pkg::COL_W-1:0]  col,
	output logic [tcw_pkg::ADDR_W-1:0] pos
);

	assign pos = tcw_pkg::ADDR_W'(row) * tcw_pkg::ADDR_W'(tcw_pkg::COLS)
		+ tcw_pkg::ADDR_W'(col);

endmodule

>>> hdl/tcw_cell_ram.sv
// Cell memory: one write port and one registered read port.
module tcw_cell_ram (
	input  logic                       clk,
	input  tcw_pkg::ram_req_t          req,
	output logic [15:0]                rdata
);

	logic [15:0] mem [tcw_pkg::CELLS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end

endmodule

>>> hdl/tcw_seq.sv
// Sequencer of the text console writer: cursor, request decode and memory sweeps.
module tcw_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           in_req,
	input  logic [7:0]           in_char,
	input  logic [7:0]           in_col,
	input  logic [7:0]           in_row,
	input  logic [7:0]           attr,
	input  logic                 out_free,
	output tcw_pkg::result_t     res,
	output tcw_pkg::ram_req_t    ram,
	input  logic [15:0]          ram_rdata
);

	typedef enum logic [7:0] {
		ST_INIT   = 8'b0000_0001,
		ST_IDLE   = 8'b0000_0010,
		ST_DECODE = 8'b0000_0100,
		ST_READ   = 8'b0000_1000,
		ST_SCROLL = 8'b0001_0000,
		ST_BLANK  = 8'b0010_0000,
		ST_FILL   = 8'b0100_0000,
		ST_DONE   = 8'b1000_0000
	} state_t;

	state_t                      state_q;
	logic [tcw_pkg::COL_W-1:0]   cur_col_q;
	logic [tcw_pkg::ROW_W-1:0]   cur_row_q;
	logic [tcw_pkg::ADDR_W-1:0]  ptr_q;
	logic                        cp_valid_s1;
	logic [tcw_pkg::ADDR_W-1:0]  cp_addr_s1;

	tcw_pkg::req_t               req_q;
	logic [7:0]                  char_q;
	logic [tcw_pkg::COL_W-1:0]   col_q;
	logic [tcw_pkg::ROW_W-1:0]   row_q;
	logic [15:0]                 cell_q;

	logic [tcw_pkg::COL_W-1:0]   au_col;
	logic [tcw_pkg::ROW_W-1:0]   au_row;
	logic [tcw_pkg::ADDR_W-1:0]  au_pos;

	logic                        is_ctrl_char;
	logic [tcw_pkg::COL_W-1:0]   next_col;
	logic [tcw_pkg::ROW_W:0]     next_row;
	logic [tcw_pkg::ROW_W:0]     row_inc;

	// The read request addresses the clamped coordinates, all else the cursor.
	always_comb begin
		if (state_q == ST_DECODE && req_q == tcw_pkg::REQ_READ) begin
			au_col = col_q;
			au_row = row_q;
		end else begin
			au_col = cur_col_q;
			au_row = cur_row_q;
		end
	end

	tcw_addr_unit u_addr (
		.row (au_row),
		.col (au_col),
		.pos (au_pos)
	);

	assign is_ctrl_char = (char_q == tcw_pkg::CH_LINE_FEED) || (char_q == tcw_pkg::CH_CARRIAGE);
	assign row_inc      = {1'b0, cur_row_q} + (tcw_pkg::ROW_W+1)'(1);

	always_comb begin
		next_col = cur_col_q;
		next_row = {1'b0, cur_row_q};
		if (char_q == tcw_pkg::CH_LINE_FEED) begin
			next_col = '0;
			next_row = row_inc;
		end else if (char_q == tcw_pkg::CH_CARRIAGE) begin
			next_col = '0;
		end else if (cur_col_q == tcw_pkg::COL_W'(tcw_pkg::COLS - 1)) begin
			next_col = '0;
			next_row = row_inc;
		end else begin
			next_col = cur_col_q + tcw_pkg::COL_W'(1);
		end
	end

	// A pending scroll copy owns the write port; the other sweeps wait for it.
	always_comb begin
		ram.we    = 1'b0;
		ram.waddr = ptr_q;
		ram.wdata = {attr, tcw_pkg::CH_SPACE};
		ram.raddr = au_pos;
		if (state_q == ST_SCROLL) begin
			ram.raddr = ptr_q + tcw_pkg::ADDR_W'(tcw_pkg::COLS);
		end
		if (cp_valid_s1) begin
			ram.we    = 1'b1;
			ram.waddr = cp_addr_s1;
			ram.wdata = ram_rdata;
		end else begin
			case (state_q)
				ST_INIT: begin
					ram.we    = 1'b1;
					ram.wdata = tcw_pkg::RESET_CELL;
				end
				ST_FILL, ST_BLANK: begin
					ram.we = 1'b1;
				end
				ST_DECODE: begin
					if (req_q == tcw_pkg::REQ_PUT && !is_ctrl_char) begin
						ram.we    = 1'b1;
						ram.waddr = au_pos;
						ram.wdata = {attr, char_q};
					end
				end
				default: begin
					ram.we = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			ptr_q       <= '0;
			cp_valid_s1 <= 1'b0;
		end else begin
			cp_valid_s1 <= (state_q == ST_SCROLL);
			case (state_q)
				ST_INIT: begin
					if (ptr_q == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1)) begin
						ptr_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + tcw_pkg::ADDR_W'(1);
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					case (req_q)
						tcw_pkg::REQ_PUT: begin
							cur_col_q <= next_col;
							if (next_row == (tcw_pkg::ROW_W+1)'(tcw_pkg::ROWS)) begin
								cur_row_q <= tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
								ptr_q     <= '0;
								state_q   <= ST_SCROLL;
							end else begin
								cur_row_q <= next_row[tcw_pkg::ROW_W-1:0];
								state_q   <= ST_DONE;
							end
						end
						tcw_pkg::REQ_CLEAR: begin
							cur_col_q <= '0;
							cur_row_q <= '0;
							ptr_q     <= '0;
							state_q   <= ST_FILL;
						end
						tcw_pkg::REQ_MOVE: begin
							cur_col_q <= col_q;
							cur_row_q <= row_q;
							state_q   <= ST_DONE;
						end
						tcw_pkg::REQ_READ: begin
							state_q <= ST_READ;
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_READ: begin
					state_q <= ST_DONE;
				end
				ST_SCROLL: begin
					if (ptr_q == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - tcw_pkg::COLS - 1)) begin
						ptr_q   <= tcw_pkg::ADDR_W'(tcw_pkg::CELLS - tcw_pkg::COLS);
						state_q <= ST_BLANK;
					end else begin
						ptr_q <= ptr_q + tcw_pkg::ADDR_W'(1);
					end
				end
				ST_BLANK, ST_FILL: begin
					if (!cp_valid_s1) begin
						if (ptr_q == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1)) begin
							state_q <= ST_DONE;
						end else begin
							ptr_q <= ptr_q + tcw_pkg::ADDR_W'(1);
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		cp_addr_s1 <= ptr_q;
		if (state_q == ST_IDLE && in_valid) begin
			req_q  <= tcw_pkg::req_t'(in_req);
			char_q <= in_char;
			col_q  <= (in_col >= 8'(tcw_pkg::COLS)) ? tcw_pkg::COL_W'(tcw_pkg::COLS - 1)
				: in_col[tcw_pkg::COL_W-1:0];
			row_q  <= (in_row >= 8'(tcw_pkg::ROWS)) ? tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)
				: in_row[tcw_pkg::ROW_W-1:0];
			cell_q <= '0;
		end else if (state_q == ST_READ) begin
			cell_q <= ram_rdata;
		end
	end

	assign in_ready     = (state_q == ST_IDLE);
	assign res.valid    = (state_q == ST_DONE) && out_free;
	assign res.cell_val = cell_q;
	assign res.col      = cur_col_q;
	assign res.row      = cur_row_q;
	assign res.pos      = au_pos;

endmodule

>>> hdl/text_console_writer.sv
// Top level of the text console writer: ports, color registers and result register.
//
// Channel   Direction  Handshake                  Payload
// s_*       in         s_tvalid / s_tready        s_tuser request kind, s_tdata char/col/row
// m_*       out        m_tvalid / m_tready        m_tdata cell, cursor, linear position
// cfg_*     in         cfg_valid / cfg_ready      cfg_index register, cfg_data value
//
// Read items pass through an extra read state to wait out the registered memory read.
// A clear walks all COLS*ROWS cells, one per cycle.
// A put that runs past the last row copies through the cell memory's single write
// port and then blanks the last row.
// After reset the block sweeps every cell of the memory to blank spaces and takes
// no item meanwhile; configuration writes are always taken.
// A result waiting on m_tready holds the sequencer in its final step.
module text_console_writer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	input  logic [23:0] s_tdata,   // [7:0] char_code, [15:8] col, [23:16] row
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [15:0] cell_value, [22:16] cursor_col,
	                               // [27:23] cursor_row, [38:28] hw_cursor_pos, [39] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [3:0]  cfg_data
);

	logic [3:0]         fg_q;
	logic [3:0]         bg_q;
	logic               m_tvalid_q;
	logic [39:0]        m_tdata_q;
	logic               out_free;
	tcw_pkg::result_t   res;
	tcw_pkg::ram_req_t  ram;
	logic [15:0]        ram_rdata;

	// Color registers; the attribute byte is background over foreground.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= tcw_pkg::RESET_FG;
			bg_q <= tcw_pkg::RESET_BG;
		end else if (cfg_valid) begin
			if (cfg_index == tcw_pkg::REG_FG_COLOR) begin
				fg_q <= cfg_data;
			end else if (cfg_index == tcw_pkg::REG_BG_COLOR) begin
				bg_q <= cfg_data;
			end
		end
	end

	tcw_cell_ram u_ram (
		.clk   (clk),
		.req   (ram),
		.rdata (ram_rdata)
	);

	tcw_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_req    (s_tuser),
		.in_char   (s_tdata[7:0]),
		.in_col    (s_tdata[15:8]),
		.in_row    (s_tdata[23:16]),
		.attr      ({bg_q, fg_q}),
		.out_free  (out_free),
		.res       (res),
		.ram       (ram),
		.ram_rdata (ram_rdata)
	);

	// The output register takes a new result whenever it is empty or being drained.
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res.valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			m_tdata_q <= {1'b0,
				tcw_pkg::OUT_POS_W'(res.pos),
				tcw_pkg::OUT_ROW_W'(res.row),
				tcw_pkg::OUT_COL_W'(res.col),
				res.cell_val};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

>>> hdl/tcw_checker.sv
// Port-level checker of the text console writer and its bind.
`include "assert_macros.svh"

module tcw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	// A stalled result stays offered.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)

	// The block works on one item at a time: right after an accept it is busy.
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// The reported cursor always lies on the screen.
	`ASSERT_IMPLY(a_cursor_range, clk, arst_n, m_tvalid, ({1'b0, m_tdata[22:16]} < 8'(tcw_pkg::COLS)) && ({3'b000, m_tdata[27:23]} < 8'(tcw_pkg::ROWS)))

	// The linear position agrees with the reported row and column.
	`ASSERT_IMPLY(a_pos_match, clk, arst_n, m_tvalid, m_tdata[38:28] == 11'(m_tdata[27:23]) * 11'(tcw_pkg::COLS) + 11'(m_tdata[22:16]))

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> sim/text_console_writer_tb.sv
// Self-checking testbench of the text console writer with its own screen predictor.
module text_console_writer_tb;

	// Register indexes past the two color registers; the block must ignore writes to them.
	localparam logic [7:0] REG_UNUSED_LOW = 8'd2;
	localparam logic [7:0] REG_UNUSED_TOP = 8'hFF;

	// A clear or a scroll walks the whole cell store, so the guard is sized for
	// every request taking a full walk plus stalls on both sides, several times over.
	localparam int CYCLE_LIMIT = 20_000_000;

	// One result item as the block reports it.
	typedef struct packed {
		logic [15:0] cell_val;
		logic [6:0]  col;
		logic [4:0]  row;
		logic [10:0] pos;
	} cursor_report_t;

	// Tracks the screen, the cursor and the colors, and holds the reports that
	// the block still owes, oldest first.
	class screen_predictor;
		logic [15:0]    cells [tcw_pkg::CELLS];
		int unsigned    cur_col;
		int unsigned    cur_row;
		logic [3:0]     fg;
		logic [3:0]     bg;
		cursor_report_t owed_reports [$];
		int             mismatches;
		int             kind_count [4];
		int             scroll_count;
		int             reg_writes;

		function new();
			foreach (cells[i]) cells[i] = tcw_pkg::RESET_CELL;
			cur_col = 0;
			cur_row = 0;
			fg = tcw_pkg::RESET_FG;
			bg = tcw_pkg::RESET_BG;
			mismatches = 0;
			scroll_count = 0;
			reg_writes = 0;
			foreach (kind_count[i]) kind_count[i] = 0;
		endfunction

		function int unsigned clamp_coord(logic [7:0] v, int unsigned lim);
			return (v >= lim) ? lim - 1 : v;
		endfunction

		function void set_register(logic [7:0] idx, logic [3:0] val);
			reg_writes++;
			if (idx == tcw_pkg::REG_FG_COLOR) begin
				fg = val;
			end else if (idx == tcw_pkg::REG_BG_COLOR) begin
				bg = val;
			end
		endfunction

		// Applies one accepted request and queues the report it must produce.
		function void note_request(tcw_pkg::req_t req, logic [7:0] ch, logic [7:0] c,
			logic [7:0] r);
			cursor_report_t rep;
			rep.cell_val = '0;
			kind_count[req]++;
			case (req)
				tcw_pkg::REQ_PUT: begin
					if (ch == tcw_pkg::CH_LINE_FEED) begin
						cur_col = 0;
						cur_row++;
					end else if (ch == tcw_pkg::CH_CARRIAGE) begin
						cur_col = 0;
					end else begin
						cells[cur_row * tcw_pkg::COLS + cur_col] = {bg, fg, ch};
						cur_col++;
						if (cur_col >= tcw_pkg::COLS) begin
							cur_col = 0;
							cur_row++;
						end
					end
					// Running off the bottom shifts everything up one row.
					if (cur_row >= tcw_pkg::ROWS) begin
						for (int i = 0; i < tcw_pkg::CELLS - tcw_pkg::COLS; i++)
							cells[i] = cells[i + tcw_pkg::COLS];
						for (int i = tcw_pkg::CELLS - tcw_pkg::COLS; i < tcw_pkg::CELLS; i++)
							cells[i] = {bg, fg, tcw_pkg::CH_SPACE};
						cur_row = tcw_pkg::ROWS - 1;
						scroll_count++;
					end
				end
				tcw_pkg::REQ_CLEAR: begin
					foreach (cells[i]) cells[i] = {bg, fg, tcw_pkg::CH_SPACE};
					cur_col = 0;
					cur_row = 0;
				end
				tcw_pkg::REQ_MOVE: begin
					cur_col = clamp_coord(c, tcw_pkg::COLS);
					cur_row = clamp_coord(r, tcw_pkg::ROWS);
				end
				default: begin
					rep.cell_val = cells[clamp_coord(r, tcw_pkg::ROWS) * tcw_pkg::COLS
						+ clamp_coord(c, tcw_pkg::COLS)];
				end
			endcase
			rep.col = cur_col[6:0];
			rep.row = cur_row[4:0];
			rep.pos = 11'(cur_row * tcw_pkg::COLS + cur_col);
			owed_reports.push_back(rep);
		endfunction

		function void check_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				mismatches++;
			end
		endfunction

		// Compares one accepted result item with the oldest owed report.
		function void check_result(logic [39:0] data);
			cursor_report_t want;
			if (owed_reports.size() == 0) begin
				$error("result item 0x%0h arrived with no request outstanding", data);
				mismatches++;
				return;
			end
			want = owed_reports.pop_front();
			check_field("cell_value", want.cell_val, data[15:0]);
			check_field("cursor_col", want.col, data[22:16]);
			check_field("cursor_row", want.row, data[27:23]);
			check_field("hw_cursor_pos", want.pos, data[38:28]);
		endfunction

		function int outstanding();
			return owed_reports.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [1:0]  s_tuser;   // [1:0] req_type
	logic [23:0] s_tdata;   // [7:0] char_code, [15:8] col, [23:16] row
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // [15:0] cell_value, [22:16] cursor_col,
	                        // [27:23] cursor_row, [38:28] hw_cursor_pos
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_index;
	logic [3:0]  cfg_data;

	screen_predictor pred;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          cycle_count = 0;

	text_console_writer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// The guard ends a hung run with the failure message.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("[text_console_writer] ERROR");
		$finish;
	end

	// The receiver checks each accepted result item and then decides whether it
	// stalls in the next cycle. Handshake signals are sampled right after the edge,
	// so they still hold the values that were in effect at the edge.
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				pred.check_result(m_tdata);
			end
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Offers one request, possibly after a random gap, and notes it once the
	// block takes it. The valid is left high so that back-to-back items never
	// lower and raise it in the same time step; stop_sending lowers it.
	task automatic send_request(tcw_pkg::req_t req, logic [7:0] ch, logic [7:0] c,
		logic [7:0] r);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {r, c, ch};
		do @(posedge clk); while (!s_tready);
		pred.note_request(req, ch, c, r);
	endtask

	task automatic stop_sending();
		s_tvalid <= 1'b0;
	endtask

	// Writes one register; the valid stays high across a batch of writes.
	task automatic write_reg(logic [7:0] idx, logic [3:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		pred.set_register(idx, val);
	endtask

	// Holds the sender off until every owed report has come back.
	task automatic wait_for_reports();
		while (pred.outstanding() != 0) @(posedge clk);
	endtask

	// Coordinates mostly stay near the screen so that moves do not all land on
	// the last row; now and then the whole byte range is used.
	function automatic logic [7:0] pick_coord(int unsigned near_limit);
		if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, near_limit));
	endfunction

	// Random requests: mostly puts of random bytes, with line feeds, carriage returns,
	// moves, reads and a few clears mixed in. Clears and scrolls walk the whole
	// store, so they are kept rare.
	task automatic send_random(int count);
		int             pick;
		tcw_pkg::req_t  req;
		logic [7:0]     ch;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			ch = 8'($urandom_range(0, 255));
			if (pick < 55) begin
				req = tcw_pkg::REQ_PUT;
				if (pick < 3) begin
					ch = tcw_pkg::CH_LINE_FEED;
				end else if (pick < 5) begin
					ch = tcw_pkg::CH_CARRIAGE;
				end
			end else if (pick < 57) begin
				req = tcw_pkg::REQ_CLEAR;
			end else if (pick < 75) begin
				req = tcw_pkg::REQ_MOVE;
			end else begin
				req = tcw_pkg::REQ_READ;
			end
			send_request(req, ch, pick_coord(90), pick_coord(27));
		end
	endtask

	initial begin
		pred = new();
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tuser   <= '0;
		s_tdata   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, under the reset colors: reset contents, byte extremes,
		// control bytes stored as characters, carriage return, line feed, wrap at
		// the end of a line, scroll by wrap and by line feed, clamping and clear.
		send_idle_pct = 12;
		recv_idle_pct = 77;
		send_request(tcw_pkg::REQ_READ, 8'h00, 8'd0, 8'd0);
		send_request(tcw_pkg::REQ_READ, 8'hFF, 8'd255, 8'd255);
		send_request(tcw_pkg::REQ_PUT, 8'h41, 8'd0, 8'd0);
		send_request(tcw_pkg::REQ_PUT, 8'hFF, 8'd0, 8'd0);
		send_request(tcw_pkg::REQ_PUT, 8'h00, 8'd0, 8'd0);
		send_request(tcw_pkg::REQ_PUT, 8'h80, 8'd0, 8'd0);
		send_request(tcw_pkg::REQ_READ, 8'h00, 8'd1, 8'd0);
		send_request(tcw_pkg::REQ_PUT, tcw_pkg::CH_CARRIAGE, 8'd0, 8'd0);
		send_request(tcw_pkg::REQ_PUT, tcw_pkg::CH_LINE_FEED, 8'd0, 8'd0);
		send_request(tcw_pkg::REQ_PUT, 8'h08, 8'd0, 8'd0);
		send_request(tcw_pkg::REQ_MOVE, 8'h00, 8'd255, 8'd255);
		send_request(tcw_pkg::REQ_PUT, 8'h5A, 8'd0, 8'd0);
		send_request(tcw_pkg::REQ_READ, 8'h00, 8'd79, 8'd23);
		send_request(tcw_pkg::REQ_READ, 8'h00, 8'd0, 8'd24);
		send_request(tcw_pkg::REQ_MOVE, 8'h00, 8'd79, 8'd0);
		send_request(tcw_pkg::REQ_PUT, 8'h7E, 8'd0, 8'd0);
		send_request(tcw_pkg::REQ_MOVE, 8'h00, 8'd0, 8'd24);
		send_request(tcw_pkg::REQ_PUT, tcw_pkg::CH_LINE_FEED, 8'd0, 8'd0);
		send_request(tcw_pkg::REQ_READ, 8'h00, 8'd0, 8'd0);
		send_request(tcw_pkg::REQ_MOVE, 8'h00, 8'd80, 8'd25);
		send_request(tcw_pkg::REQ_PUT, tcw_pkg::CH_CARRIAGE, 8'd0, 8'd0);
		send_request(tcw_pkg::REQ_CLEAR, 8'hFF, 8'hFF, 8'hFF);
		send_request(tcw_pkg::REQ_READ, 8'h00, 8'd79, 8'd24);
		send_request(tcw_pkg::REQ_MOVE, 8'hAA, 8'hAA, 8'hAA);
		send_request(tcw_pkg::REQ_READ, 8'h55, 8'h55, 8'h55);
		stop_sending();
		wait_for_reports();

		// Brightest colors; writes to unused indexes must change nothing.
		write_reg(tcw_pkg::REG_FG_COLOR, 4'hF);
		write_reg(tcw_pkg::REG_BG_COLOR, 4'hF);
		write_reg(REG_UNUSED_LOW, 4'h3);
		write_reg(REG_UNUSED_TOP, 4'hA);
		cfg_valid <= 1'b0;

		// Sender sparse gaps, receiver stalling most of the time. Halfway through,
		// the sender pauses until the block has answered everything.
		send_random(180);
		stop_sending();
		wait_for_reports();
		send_random(190);
		stop_sending();
		wait_for_reports();

		// All-zero colors, with the idling roles swapped.
		send_idle_pct = 77;
		recv_idle_pct = 12;
		write_reg(tcw_pkg::REG_FG_COLOR, 4'h0);
		write_reg(tcw_pkg::REG_BG_COLOR, 4'h0);
		cfg_valid <= 1'b0;
		send_random(370);
		stop_sending();
		wait_for_reports();

		// Full rate on both sides, first with random colors, then a fixed mix.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(tcw_pkg::REG_FG_COLOR, 4'($urandom_range(0, 15)));
		write_reg(tcw_pkg::REG_BG_COLOR, 4'($urandom_range(0, 15)));
		cfg_valid <= 1'b0;
		send_random(185);
		stop_sending();
		wait_for_reports();
		write_reg(tcw_pkg::REG_FG_COLOR, 4'hA);
		write_reg(tcw_pkg::REG_BG_COLOR, 4'h5);
		cfg_valid <= 1'b0;
		send_random(185);
		stop_sending();
		wait_for_reports();

		// A short tail catches any result item the block sends unasked.
		repeat (16) @(posedge clk);

		$display("Run covered %0d puts, %0d clears, %0d moves and %0d reads,",
			pred.kind_count[tcw_pkg::REQ_PUT], pred.kind_count[tcw_pkg::REQ_CLEAR],
			pred.kind_count[tcw_pkg::REQ_MOVE], pred.kind_count[tcw_pkg::REQ_READ]);
		$display("with %0d scrolls and %0d register writes; %0d field mismatches.",
			pred.scroll_count, pred.reg_writes, pred.mismatches);
		if (pred.mismatches == 0) begin
			$display("[text_console_writer] OK");
		end else begin
			$display("[text_console_writer] ERROR");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+hdl
hdl/tcw_pkg.sv
hdl/tcw_addr_unit.sv
hdl/tcw_cell_ram.sv
hdl/tcw_seq.sv
hdl/text_console_writer.sv
hdl/tcw_checker.sv
sim/text_console_writer_tb.sv
